// ===== hdl/ctr_pkg.sv =====
// Shared types, codes and the microprogram for the cubic trajectory replanner.
// No dependencies; every other file in hdl/ imports this package.
package ctr_pkg;

    localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

    // Request opcodes
    localparam logic [1:0] OP_PLAN   = 2'd0;
    localparam logic [1:0] OP_REPLAN = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Micro-operations
    localparam logic [2:0] UOP_ADD   = 3'd0;  // sadd(smulk(a,ca), smulk(b,cb))
    localparam logic [2:0] UOP_MULQ  = 3'd1;  // a * b / 2^30
    localparam logic [2:0] UOP_DIVQ  = 3'd2;  // a * 2^30 / b
    localparam logic [2:0] UOP_SCALE = 3'd3;  // a * TPS / length
    localparam logic [2:0] UOP_NORM  = 3'd4;  // s = dt * 2^30 / length

    // Datapath register codes
    localparam logic [4:0] R_ZERO = 5'd0;
    localparam logic [4:0] R_ONE  = 5'd1;
    localparam logic [4:0] R_CA   = 5'd2;
    localparam logic [4:0] R_CB   = 5'd3;
    localparam logic [4:0] R_CC   = 5'd4;
    localparam logic [4:0] R_CD   = 5'd5;
    localparam logic [4:0] R_SS   = 5'd6;
    localparam logic [4:0] R_SL   = 5'd7;
    localparam logic [4:0] R_TM   = 5'd8;
    localparam logic [4:0] R_X0   = 5'd9;
    localparam logic [4:0] R_G    = 5'd10;
    localparam logic [4:0] R_DUR  = 5'd11;
    localparam logic [4:0] R_S    = 5'd12;
    localparam logic [4:0] R_H    = 5'd13;
    localparam logic [4:0] R_U    = 5'd14;
    localparam logic [4:0] R_V    = 5'd15;
    localparam logic [4:0] R_W    = 5'd16;

    // Program entry points
    localparam logic [5:0] PC_PLAN   = 6'd0;
    localparam logic [5:0] PC_REPLAN = 6'd7;
    localparam logic [5:0] PC_EVAL   = 6'd34;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        sample_time;
        logic signed [31:0] start_position;
        logic signed [31:0] goal_position;
        logic [31:0]        duration;
    } ctr_in_t;

    typedef struct packed {
        logic signed [31:0] position_out;
        logic signed [31:0] velocity_out;
        logic signed [31:0] acceleration_out;
        logic               error_flag;
    } ctr_out_t;

    typedef struct packed {
        logic [2:0]        uop;
        logic [4:0]        dst;
        logic [4:0]        sa;
        logic [4:0]        sb;
        logic signed [3:0] ca;
        logic signed [3:0] cb;
        logic              last;
        logic              jmp;
    } uinst_t;

    typedef struct packed {
        logic   capture;
        logic   go;
        uinst_t ui;
        logic   load_out;
        logic   err;
    } ctr_cmd_t;

    typedef struct packed {
        logic       done;
        logic [1:0] opcode;
        logic       dur_zero;
        logic       past_end;
    } ctr_status_t;

    function automatic uinst_t mk(input logic [2:0] uop, input logic [4:0] dst,
                                  input logic [4:0] sa, input logic [4:0] sb,
                                  input int ca, input int cb,
                                  input logic last, input logic jmp);
        uinst_t u;
        u.uop  = uop;
        u.dst  = dst;
        u.sa   = sa;
        u.sb   = sb;
        u.ca   = 4'(ca);
        u.cb   = 4'(cb);
        u.last = last;
        u.jmp  = jmp;
        return u;
    endfunction

    function automatic uinst_t ucode(input logic [5:0] pc);
        uinst_t u;
        case (pc)
            // plan: rest-to-rest cubic
            6'd0:  u = mk(UOP_ADD,   R_U,  R_G,    R_X0,    1, -1, 1'b0, 1'b0);
            6'd1:  u = mk(UOP_ADD,   R_CA, R_U,    R_ZERO, -2,  0, 1'b0, 1'b0);
            6'd2:  u = mk(UOP_ADD,   R_CB, R_U,    R_ZERO,  3,  0, 1'b0, 1'b0);
            6'd3:  u = mk(UOP_ADD,   R_CC, R_ZERO, R_ZERO,  0,  0, 1'b0, 1'b0);
            6'd4:  u = mk(UOP_ADD,   R_CD, R_X0,   R_ZERO,  1,  0, 1'b0, 1'b0);
            6'd5:  u = mk(UOP_ADD,   R_SS, R_TM,   R_ZERO,  1,  0, 1'b0, 1'b0);
            6'd6:  u = mk(UOP_ADD,   R_SL, R_DUR,  R_ZERO,  1,  0, 1'b0, 1'b1);
            // replan: s0, h, p0 - g, v0*h, then B and A
            6'd7:  u = mk(UOP_NORM,  R_S,  R_TM,   R_ZERO,  0,  0, 1'b0, 1'b0);
            6'd8:  u = mk(UOP_ADD,   R_H,  R_ONE,  R_S,     1, -1, 1'b0, 1'b0);
            6'd9:  u = mk(UOP_MULQ,  R_U,  R_CA,   R_S,     0,  0, 1'b0, 1'b0);
            6'd10: u = mk(UOP_ADD,   R_U,  R_U,    R_CB,    1,  1, 1'b0, 1'b0);
            6'd11: u = mk(UOP_MULQ,  R_U,  R_U,    R_S,     0,  0, 1'b0, 1'b0);
            6'd12: u = mk(UOP_ADD,   R_U,  R_U,    R_CC,    1,  1, 1'b0, 1'b0);
            6'd13: u = mk(UOP_MULQ,  R_U,  R_U,    R_S,     0,  0, 1'b0, 1'b0);
            6'd14: u = mk(UOP_ADD,   R_U,  R_U,    R_CD,    1,  1, 1'b0, 1'b0);
            6'd15: u = mk(UOP_ADD,   R_U,  R_U,    R_G,     1, -1, 1'b0, 1'b0);
            6'd16: u = mk(UOP_ADD,   R_V,  R_CA,   R_ZERO,  3,  0, 1'b0, 1'b0);
            6'd17: u = mk(UOP_MULQ,  R_V,  R_V,    R_S,     0,  0, 1'b0, 1'b0);
            6'd18: u = mk(UOP_ADD,   R_V,  R_V,    R_CB,    1,  2, 1'b0, 1'b0);
            6'd19: u = mk(UOP_MULQ,  R_V,  R_V,    R_S,     0,  0, 1'b0, 1'b0);
            6'd20: u = mk(UOP_ADD,   R_V,  R_V,    R_CC,    1,  1, 1'b0, 1'b0);
            6'd21: u = mk(UOP_MULQ,  R_V,  R_V,    R_H,     0,  0, 1'b0, 1'b0);
            6'd22: u = mk(UOP_ADD,   R_W,  R_U,    R_V,     3,  1, 1'b0, 1'b0);
            6'd23: u = mk(UOP_DIVQ,  R_W,  R_W,    R_H,     0,  0, 1'b0, 1'b0);
            6'd24: u = mk(UOP_DIVQ,  R_W,  R_W,    R_H,     0,  0, 1'b0, 1'b0);
            6'd25: u = mk(UOP_ADD,   R_U,  R_V,    R_U,    -1, -2, 1'b0, 1'b0);
            6'd26: u = mk(UOP_DIVQ,  R_U,  R_U,    R_H,     0,  0, 1'b0, 1'b0);
            6'd27: u = mk(UOP_DIVQ,  R_U,  R_U,    R_H,     0,  0, 1'b0, 1'b0);
            6'd28: u = mk(UOP_DIVQ,  R_U,  R_U,    R_H,     0,  0, 1'b0, 1'b0);
            6'd29: u = mk(UOP_ADD,   R_CA, R_U,    R_ZERO, -1,  0, 1'b0, 1'b0);
            6'd30: u = mk(UOP_ADD,   R_CB, R_W,    R_U,     1,  3, 1'b0, 1'b0);
            6'd31: u = mk(UOP_ADD,   R_CC, R_W,    R_U,    -2, -3, 1'b0, 1'b0);
            6'd32: u = mk(UOP_ADD,   R_V,  R_G,    R_W,     1,  1, 1'b0, 1'b0);
            6'd33: u = mk(UOP_ADD,   R_CD, R_V,    R_U,     1,  1, 1'b0, 1'b1);
            // evaluate: position in U, velocity in V, acceleration in W
            6'd34: u = mk(UOP_NORM,  R_S,  R_TM,   R_ZERO,  0,  0, 1'b0, 1'b0);
            6'd35: u = mk(UOP_MULQ,  R_U,  R_CA,   R_S,     0,  0, 1'b0, 1'b0);
            6'd36: u = mk(UOP_ADD,   R_U,  R_U,    R_CB,    1,  1, 1'b0, 1'b0);
            6'd37: u = mk(UOP_MULQ,  R_U,  R_U,    R_S,     0,  0, 1'b0, 1'b0);
            6'd38: u = mk(UOP_ADD,   R_U,  R_U,    R_CC,    1,  1, 1'b0, 1'b0);
            6'd39: u = mk(UOP_MULQ,  R_U,  R_U,    R_S,     0,  0, 1'b0, 1'b0);
            6'd40: u = mk(UOP_ADD,   R_U,  R_U,    R_CD,    1,  1, 1'b0, 1'b0);
            6'd41: u = mk(UOP_ADD,   R_V,  R_CA,   R_ZERO,  3,  0, 1'b0, 1'b0);
            6'd42: u = mk(UOP_MULQ,  R_V,  R_V,    R_S,     0,  0, 1'b0, 1'b0);
            6'd43: u = mk(UOP_ADD,   R_V,  R_V,    R_CB,    1,  2, 1'b0, 1'b0);
            6'd44: u = mk(UOP_MULQ,  R_V,  R_V,    R_S,     0,  0, 1'b0, 1'b0);
            6'd45: u = mk(UOP_ADD,   R_V,  R_V,    R_CC,    1,  1, 1'b0, 1'b0);
            6'd46: u = mk(UOP_SCALE, R_V,  R_V,    R_ZERO,  0,  0, 1'b0, 1'b0);
            6'd47: u = mk(UOP_ADD,   R_W,  R_CA,   R_ZERO,  6,  0, 1'b0, 1'b0);
            6'd48: u = mk(UOP_MULQ,  R_W,  R_W,    R_S,     0,  0, 1'b0, 1'b0);
            6'd49: u = mk(UOP_ADD,   R_W,  R_W,    R_CB,    1,  2, 1'b0, 1'b0);
            6'd50: u = mk(UOP_SCALE, R_W,  R_W,    R_ZERO,  0,  0, 1'b0, 1'b0);
            6'd51: u = mk(UOP_SCALE, R_W,  R_W,    R_ZERO,  0,  0, 1'b1, 1'b0);
            default: u = mk(UOP_ADD, R_ZERO, R_ZERO, R_ZERO, 0,  0, 1'b1, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/ctr_muldiv.sv =====
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on ctr_pkg (micro-operation codes).
module ctr_muldiv #(
    parameter int unsigned TICKS_PER_SECOND = ctr_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  uop,
    input  logic [62:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [62:0] q
);
    import ctr_pkg::*;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 96;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]  ph_reg, ph_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [95:0] acc_reg, acc_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] mul_reg, mul_next;
    logic [31:0] div_reg, div_next;
    logic [62:0] a_reg, a_next;
    logic [2:0]  op_reg, op_next;
    logic [62:0] q_reg, q_next;
    logic [32:0] rem_sh, diff;
    logic        ge;

    always_comb
    begin
        ph_next   = ph_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        mul_next  = mul_reg;
        div_next  = div_reg;
        a_next    = a_reg;
        op_next   = op_reg;
        q_next    = q_reg;
        rem_sh    = {rem_reg, acc_reg[95]};
        diff      = rem_sh - {1'b0, div_reg};
        ge        = (rem_sh >= {1'b0, div_reg});
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    op_next  = uop;
                    a_next   = a;
                    cnt_next = 7'd0;
                    rem_next = 32'd0;
                    if (uop == UOP_MULQ)
                    begin
                        mul_next = b;
                        acc_next = 96'd0;
                        ph_next  = PH_MUL;
                    end
                    else if (uop == UOP_SCALE)
                    begin
                        mul_next = 32'(TICKS_PER_SECOND);
                        div_next = b;
                        acc_next = 96'd0;
                        ph_next  = PH_MUL;
                    end
                    else
                    begin
                        div_next = b;
                        acc_next = {3'b000, a, 30'd0};
                        ph_next  = PH_DIV;
                    end
                end
            end
            PH_MUL:
            begin
                acc_next = {acc_reg[94:0], 1'b0} + (mul_reg[31] ? {33'd0, a_reg} : 96'd0);
                mul_next = {mul_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(MUL_STEPS - 1))
                begin
                    cnt_next = 7'd0;
                    if (op_reg == UOP_MULQ)
                    begin
                        q_next    = acc_next[92:30];
                        done_next = 1'b1;
                        ph_next   = PH_IDLE;
                    end
                    else
                    begin
                        ph_next = PH_DIV;
                    end
                end
            end
            PH_DIV:
            begin
                rem_next = ge ? diff[31:0] : rem_sh[31:0];
                acc_next = {acc_reg[94:0], ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    // quotient at or above 2^63 saturates
                    q_next    = (|acc_next[95:63]) ? {63{1'b1}} : acc_next[62:0];
                    done_next = 1'b1;
                    ph_next   = PH_IDLE;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        mul_reg <= mul_next;
        div_reg <= div_next;
        a_reg   <= a_next;
        op_reg  <= op_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ===== hdl/ctr_datapath.sv =====
// Datapath: curve state, operands, saturating adder and the shared mul/div unit.
// Depends on ctr_pkg and ctr_muldiv.
module ctr_datapath #(
    parameter int unsigned TICKS_PER_SECOND = ctr_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctr_pkg::ctr_in_t     request,
    input  ctr_pkg::ctr_cmd_t    cmd,
    output ctr_pkg::ctr_status_t status,
    output ctr_pkg::ctr_out_t    result
);
    import ctr_pkg::*;

    localparam logic signed [63:0] BIG     = {1'b0, {63{1'b1}}};
    localparam logic signed [64:0] BIG65   = {2'b00, {63{1'b1}}};
    localparam logic signed [64:0] NBIG65  = -BIG65;
    localparam logic signed [63:0] MAX32   = 64'sd2147483647;
    localparam logic signed [63:0] MIN32   = -64'sd2147483648;
    localparam logic [63:0]        S_ONE64 = 64'h0000_0000_4000_0000;

    logic signed [63:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0]        ss_reg, sl_reg;
    logic               done_reg;
    logic [1:0]         op_reg;
    logic [31:0]        tm_reg, dur_reg;
    logic signed [31:0] x0_reg, g_reg;
    logic [30:0]        s_reg, h_reg;
    logic signed [63:0] u_reg, v_reg, w_reg;
    logic [4:0]         pend_dst_reg;
    logic               pend_neg_reg;
    ctr_out_t           result_reg;

    uinst_t             ui;
    logic signed [63:0] opa, opb, add_val, uval, wr_val;
    logic [31:0]        dt_raw, dt;
    logic               unit_start, unit_done, wr_en;
    logic [62:0]        unit_a, unit_q;
    logic [31:0]        unit_b;
    logic [4:0]         wr_dst;

    function automatic logic [62:0] mag63(input logic signed [63:0] x);
        logic [63:0] n;
        n = -x;
        return x[63] ? n[62:0] : x[62:0];
    endfunction

    // saturating multiply by a small signed constant
    function automatic logic signed [63:0] smulk(input logic signed [63:0] x,
                                                 input logic signed [3:0] c);
        logic [62:0] m;
        logic [2:0]  k;
        logic [65:0] p;
        logic [62:0] r;
        logic [63:0] r64;
        m   = mag63(x);
        k   = c[3] ? 3'(-c) : 3'(c);
        p   = {3'b000, m} * {63'd0, k};
        r   = (p > {3'b000, BIG[62:0]}) ? BIG[62:0] : p[62:0];
        r64 = {1'b0, r};
        return (x[63] ^ c[3]) ? -r64 : r64;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s > BIG65)
            return BIG;
        else if (s < NBIG65)
            return -BIG;
        else
            return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > MAX32)
            return MAX32[31:0];
        else if (x < MIN32)
            return MIN32[31:0];
        else
            return x[31:0];
    endfunction

    function automatic logic signed [63:0] rd(input logic [4:0] code);
        logic signed [63:0] r;
        case (code)
            R_ZERO:  r = 64'sd0;
            R_ONE:   r = S_ONE64;
            R_CA:    r = ca_reg;
            R_CB:    r = cb_reg;
            R_CC:    r = cc_reg;
            R_CD:    r = cd_reg;
            R_SS:    r = {32'd0, ss_reg};
            R_SL:    r = {32'd0, sl_reg};
            R_TM:    r = {32'd0, tm_reg};
            R_X0:    r = {{32{x0_reg[31]}}, x0_reg};
            R_G:     r = {{32{g_reg[31]}}, g_reg};
            R_DUR:   r = {32'd0, dur_reg};
            R_S:     r = {33'd0, s_reg};
            R_H:     r = {33'd0, h_reg};
            R_U:     r = u_reg;
            R_V:     r = v_reg;
            R_W:     r = w_reg;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        ui         = cmd.ui;
        opa        = rd(ui.sa);
        opb        = rd(ui.sb);
        add_val    = sadd(smulk(opa, ui.ca), smulk(opb, ui.cb));
        // elapsed time clamped to the segment
        dt_raw     = (tm_reg > ss_reg) ? (tm_reg - ss_reg) : 32'd0;
        dt         = (dt_raw > sl_reg) ? sl_reg : dt_raw;
        unit_start = cmd.go && (ui.uop != UOP_ADD);
        unit_a     = (ui.uop == UOP_NORM) ? {31'd0, dt} : mag63(opa);
        unit_b     = ((ui.uop == UOP_SCALE) || (ui.uop == UOP_NORM)) ? sl_reg : opb[31:0];
        uval       = pend_neg_reg ? -{1'b0, unit_q} : {1'b0, unit_q};
        wr_en      = (cmd.go && (ui.uop == UOP_ADD)) || unit_done;
        wr_dst     = unit_done ? pend_dst_reg : ui.dst;
        wr_val     = unit_done ? uval : add_val;
    end

    ctr_muldiv #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .uop   (ui.uop),
        .a     (unit_a),
        .b     (unit_b),
        .done  (unit_done),
        .q     (unit_q)
    );

    // curve state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg   <= 64'sd0;
            cb_reg   <= 64'sd0;
            cc_reg   <= 64'sd0;
            cd_reg   <= 64'sd0;
            ss_reg   <= 32'd0;
            sl_reg   <= 32'd1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= wr_en;
            if (wr_en && (wr_dst == R_CA)) ca_reg <= wr_val;
            if (wr_en && (wr_dst == R_CB)) cb_reg <= wr_val;
            if (wr_en && (wr_dst == R_CC)) cc_reg <= wr_val;
            if (wr_en && (wr_dst == R_CD)) cd_reg <= wr_val;
            if (wr_en && (wr_dst == R_SS)) ss_reg <= wr_val[31:0];
            if (wr_en && (wr_dst == R_SL)) sl_reg <= wr_val[31:0];
        end
    end

    // item operands, scratch and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= request.opcode;
            tm_reg  <= request.sample_time;
            x0_reg  <= request.start_position;
            g_reg   <= request.goal_position;
            dur_reg <= request.duration;
        end
        if (unit_start)
        begin
            pend_dst_reg <= ui.dst;
            pend_neg_reg <= (ui.uop != UOP_NORM) && opa[63];
        end
        if (wr_en && (wr_dst == R_S)) s_reg <= wr_val[30:0];
        if (wr_en && (wr_dst == R_H)) h_reg <= wr_val[30:0];
        if (wr_en && (wr_dst == R_U)) u_reg <= wr_val;
        if (wr_en && (wr_dst == R_V)) v_reg <= wr_val;
        if (wr_en && (wr_dst == R_W)) w_reg <= wr_val;
        if (cmd.load_out)
        begin
            result_reg.position_out     <= sat32(u_reg);
            result_reg.velocity_out     <= sat32(v_reg);
            result_reg.acceleration_out <= sat32(w_reg);
            result_reg.error_flag       <= cmd.err;
        end
    end

    assign status.done     = done_reg;
    assign status.opcode   = op_reg;
    assign status.dur_zero = (dur_reg == 32'd0);
    assign status.past_end = ({1'b0, tm_reg} >= ({1'b0, ss_reg} + {1'b0, sl_reg}));
    assign result          = result_reg;

endmodule

// ===== hdl/ctr_ctrl.sv =====
// Controller: handshakes, program selection and microprogram sequencing.
// Depends on ctr_pkg (command/status types, microprogram).
module ctr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 request_valid,
    input  logic                 result_stall,
    input  ctr_pkg::ctr_status_t status,
    output logic                 request_stall,
    output logic                 result_valid,
    output ctr_pkg::ctr_cmd_t    cmd
);
    import ctr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_WAIT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    logic       err_reg, err_next;
    logic       full_reg, full_next;

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        err_next     = err_reg;
        cmd          = '0;
        cmd.ui       = ucode(pc_reg);
        cmd.err      = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (request_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                err_next = ((status.opcode == OP_PLAN) && status.dur_zero) ||
                           ((status.opcode == OP_REPLAN) && status.past_end);
                if ((status.opcode == OP_PLAN) && !status.dur_zero)
                    pc_next = PC_PLAN;
                else if ((status.opcode == OP_REPLAN) && !status.past_end)
                    pc_next = PC_REPLAN;
                else
                    pc_next = PC_EVAL;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.go     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.done)
                begin
                    if (cmd.ui.last)
                        state_next = ST_DONE;
                    else
                    begin
                        pc_next    = cmd.ui.jmp ? PC_EVAL : (pc_reg + 6'd1);
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_DONE:
            begin
                if (!full_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load_out)
            full_next = 1'b1;
        else if (full_reg && !result_stall)
            full_next = 1'b0;
        else
            full_next = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_EVAL;
            err_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            err_reg   <= err_next;
            full_reg  <= full_next;
        end
    end

    assign request_stall = (state_reg != ST_IDLE);
    assign result_valid  = full_reg;

endmodule

// ===== hdl/cubic_trajectory_replanner.sv =====
// Top level of the cubic trajectory replanner: controller plus datapath.
// Depends on ctr_pkg, ctr_ctrl, ctr_datapath (and ctr_muldiv below it).
//
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------
//  request | request_valid / request_stall | ctr_in_t: opcode, time, positions,
//          |                              | duration
//  result  | result_valid / result_stall  | ctr_out_t: position, velocity,
//          |                              | acceleration, error flag
//
// Items: one item at a time. The run time of an item is set mostly by the shared
//   bit-serial multiply/divide unit, which does multiplies, divides and time
//   scaling, plus the sequencing of each micro-operation.
// Reset: rst_n clears the curve to zero, segment start 0, length 1.
// Stalls: a finished result sits in the output register; the next request
//   transfer is taken while it waits, and only the final load waits for it.
module cubic_trajectory_replanner #(
    parameter int unsigned TICKS_PER_SECOND = ctr_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_stall,
    input  ctr_pkg::ctr_in_t  request,
    output logic              result_valid,
    input  logic              result_stall,
    output ctr_pkg::ctr_out_t result
);
    import ctr_pkg::*;

    ctr_cmd_t    cmd;
    ctr_status_t status;

    // sequencer: picks plan / replan / evaluate program, steps it, owns handshakes
    ctr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .result_stall  (result_stall),
        .status        (status),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .cmd           (cmd)
    );

    // coefficients, operands and arithmetic; result register lives here
    ctr_datapath #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

// ===== hdl/ctr_checker.sv =====
// Port-level checker for the cubic trajectory replanner, bound to the top level.
// Depends on ctr_pkg (result type) and cubic_trajectory_replanner.
module ctr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              request_valid,
    input logic              request_stall,
    input logic              result_valid,
    input logic              result_stall,
    input ctr_pkg::ctr_out_t result
);
    import ctr_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result valid dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (request_valid && !request_stall) |=> request_stall)
        else $error("request taken without going busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(request_stall))
        else $error("result appeared without an item in work");

endmodule

bind cubic_trajectory_replanner ctr_checker u_ctr_checker (.*);

// ===== test/cubic_trajectory_replanner_tb.sv =====
// Self-checking bench for cubic_trajectory_replanner: directed rows, then random
// plan/replan/sample traffic with random gaps and back-pressure. Needs ctr_pkg.
module cubic_trajectory_replanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctr_pkg::*;

    localparam int unsigned    TPS      = 1000000;
    localparam int             S_SHIFT  = 30;
    localparam longint unsigned S_UNIT  = 64'd1 << S_SHIFT;
    localparam longint unsigned S_FRAC  = S_UNIT - 1;
    localparam longint unsigned MAX_MAG = 64'h7fff_ffff_ffff_ffff;
    localparam longint          MAX_POS = 64'sh7fff_ffff_ffff_ffff;
    localparam logic [1:0]      OP_SPARE = 2'd3;   // unused code, behaves as sample
    localparam int              RANDOM_ITEMS = 1430;

    logic     clk;
    logic     rst_n;
    logic     request_valid;
    logic     request_stall;
    ctr_in_t  request;
    logic     result_valid;
    logic     result_stall;
    ctr_out_t result;

    cubic_trajectory_replanner uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    // Curve held by the predictor: p(s) = cubic*s^3 + square*s^2 + linear*s + constant
    longint      crv_cubic, crv_square, crv_linear, crv_constant;
    int unsigned seg_begin, seg_len;

    ctr_out_t    pending_results[$];
    int          mismatches;
    bit          quiet;        // burst mode: no gaps, no back-pressure
    bit          stim_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    //--------------------------------------------------------------------
    // Saturating fixed-point helpers (magnitude arithmetic, sign applied last)
    //--------------------------------------------------------------------
    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint signed_clip(input longint unsigned m, input bit neg);
        longint v;
        v = (m > MAX_MAG) ? MAX_POS : longint'(m);
        return neg ? -v : v;
    endfunction

    function automatic longint add_sat(input longint x, input longint y);
        if (y > 0 && x > MAX_POS - y) return MAX_POS;
        if (y < 0 && x < -MAX_POS - y) return -MAX_POS;
        return x + y;
    endfunction

    function automatic longint times_k(input longint x, input longint unsigned k);
        longint unsigned m;
        m = magnitude(x);
        if (k != 0 && m > MAX_MAG / k) return signed_clip(MAX_MAG, x < 0);
        return signed_clip(m * k, x < 0);
    endfunction

    // x * m / 2^30
    function automatic longint frac_mul(input longint x, input longint unsigned m);
        longint unsigned a, r;
        a = magnitude(x);
        r = (a >> S_SHIFT) * m + (((a & S_FRAC) * m) >> S_SHIFT);
        return signed_clip(r, x < 0);
    endfunction

    // x * 2^30 / h
    function automatic longint frac_div(input longint x, input longint unsigned h);
        longint unsigned a, q, r;
        a = magnitude(x);
        q = a / h;
        r = a % h;
        if (q > (MAX_MAG >> S_SHIFT)) return signed_clip(MAX_MAG, x < 0);
        return signed_clip((q << S_SHIFT) + ((r << S_SHIFT) / h), x < 0);
    endfunction

    // x * k / len, per-second rescaling
    function automatic longint rate_scale(input longint x, input longint unsigned k,
                                          input longint unsigned len);
        longint unsigned a, q, r;
        a = magnitude(x);
        q = a / len;
        r = a % len;
        if (q > MAX_MAG / k) return signed_clip(MAX_MAG, x < 0);
        return signed_clip(longint'(add_sat(longint'(q * k), longint'((r * k) / len))),
                           x < 0);
    endfunction

    function automatic longint unsigned seg_phase(input logic [31:0] t);
        longint unsigned len, dt;
        len = (seg_len != 0) ? seg_len : 1;
        dt  = (t > seg_begin) ? longint'(t) - seg_begin : 0;
        if (dt > len) dt = len;
        return (dt << S_SHIFT) / len;
    endfunction

    function automatic longint curve_pos(input longint unsigned s);
        longint p;
        p = add_sat(frac_mul(crv_cubic, s), crv_square);
        p = add_sat(frac_mul(p, s), crv_linear);
        return add_sat(frac_mul(p, s), crv_constant);
    endfunction

    function automatic longint curve_slope(input longint unsigned s);
        longint p;
        p = add_sat(frac_mul(times_k(crv_cubic, 3), s), times_k(crv_square, 2));
        return add_sat(frac_mul(p, s), crv_linear);
    endfunction

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // Hermite refit on [s0,1]: keep position and slope at s0, land at rest on goal
    function automatic void refit_to_goal(input longint g, input longint unsigned s0);
        longint unsigned h;
        longint p0, v0, dp, vh, quad, cub;
        h    = S_UNIT - s0;
        p0   = curve_pos(s0);
        v0   = curve_slope(s0);
        dp   = add_sat(p0, -g);
        vh   = frac_mul(v0, h);
        quad = frac_div(frac_div(add_sat(times_k(dp, 3), vh), h), h);
        cub  = frac_div(frac_div(frac_div(add_sat(-vh, -times_k(dp, 2)), h), h), h);
        crv_cubic    = -cub;
        crv_square   = add_sat(quad, times_k(cub, 3));
        crv_linear   = add_sat(-times_k(quad, 2), -times_k(cub, 3));
        crv_constant = add_sat(add_sat(g, quad), cub);
    endfunction

    // Applies one request to the predicted state and returns the result it yields
    function automatic ctr_out_t predict_motion(input ctr_in_t rq);
        ctr_out_t        o;
        bit              rejected;
        longint          x0, g, d, vel, acc;
        longint unsigned s, len;
        rejected = 1'b0;
        x0 = longint'(rq.start_position);
        g  = longint'(rq.goal_position);
        if (rq.opcode == OP_PLAN)
        begin
            if (rq.duration == 0)
                rejected = 1'b1;
            else
            begin
                d            = g - x0;
                crv_cubic    = -2 * d;
                crv_square   = 3 * d;
                crv_linear   = 0;
                crv_constant = x0;
                seg_begin    = rq.sample_time;
                seg_len      = rq.duration;
            end
        end
        else if (rq.opcode == OP_REPLAN)
        begin
            if (longint'(rq.sample_time) >= longint'(seg_begin) + longint'(seg_len))
                rejected = 1'b1;
            else
                refit_to_goal(g, seg_phase(rq.sample_time));
        end
        s   = seg_phase(rq.sample_time);
        len = (seg_len != 0) ? seg_len : 1;
        vel = rate_scale(curve_slope(s), TPS, len);
        acc = add_sat(frac_mul(times_k(crv_cubic, 6), s), times_k(crv_square, 2));
        acc = rate_scale(rate_scale(acc, TPS, len), TPS, len);
        o.position_out     = clip32(curve_pos(s));
        o.velocity_out     = clip32(vel);
        o.acceleration_out = clip32(acc);
        o.error_flag       = rejected;
        return o;
    endfunction

    //--------------------------------------------------------------------
    // Request side
    //--------------------------------------------------------------------
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    // One request transfer; valid stays high across back-to-back transfers
    task automatic push_request(input ctr_in_t rq, input bit typed, input ctr_out_t want);
        int       gap;
        ctr_out_t model;
        gap = draw_gap();
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request       <= rq;
        request_valid <= 1'b1;
        @(posedge clk);
        while (request_stall) @(posedge clk);
        model = predict_motion(rq);
        pending_results.push_back(typed ? want : model);
    endtask

    typedef struct {
        ctr_in_t  rq;
        bit       typed;
        ctr_out_t want;
    } probe_t;

    probe_t probes[$];

    function automatic ctr_in_t mk_req(input logic [1:0] op, input logic [31:0] t,
                                       input logic [31:0] x0, input logic [31:0] g,
                                       input logic [31:0] dur);
        ctr_in_t r;
        r.opcode         = op;
        r.sample_time    = t;
        r.start_position = x0;
        r.goal_position  = g;
        r.duration       = dur;
        return r;
    endfunction

    function automatic void add_probe(input ctr_in_t rq, input bit typed,
                                      input logic [31:0] p, input logic [31:0] v,
                                      input logic [31:0] a, input logic e);
        probe_t pr;
        pr.rq    = rq;
        pr.typed = typed;
        pr.want  = '{position_out: p, velocity_out: v, acceleration_out: a,
                     error_flag: e};
        probes.push_back(pr);
    endfunction

    // Random item: mostly coherent motion around the live segment, some noise
    function automatic ctr_in_t random_request();
        ctr_in_t         r;
        int unsigned     pick;
        longint unsigned span, t;
        r = mk_req(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        span = (seg_len != 0) ? seg_len : 1;
        t = longint'(seg_begin) + ($urandom % (span + span / 8 + 1));
        if ($urandom_range(0, 9) == 0)
            t = t - ($urandom % (span / 4 + 1));
        if (pick < 8)
            return r;                                   // fully random fields
        if ($urandom_range(0, 3) != 0)
        begin
            r.start_position = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
            r.goal_position  = $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
        end
        if (pick < 28)
        begin
            r.opcode      = OP_PLAN;
            r.sample_time = (pick < 26) ? t[31:0] : $urandom;
            case ($urandom_range(0, 9))
                0:       r.duration = $urandom_range(1, 8);
                1:       r.duration = $urandom;
                2:       r.duration = (pick & 1) ? 32'd0 : 32'hffff_ffff;
                default: r.duration = $urandom_range(1000, 3000000);
            endcase
        end
        else if (pick < 68)
        begin
            r.opcode      = OP_REPLAN;
            r.sample_time = t[31:0];
        end
        else if (pick < 95)
        begin
            r.opcode      = OP_SAMPLE;
            r.sample_time = t[31:0];
        end
        else
        begin
            r.opcode      = OP_SPARE;
            r.sample_time = t[31:0];
        end
        return r;
    endfunction

    initial
    begin
        ctr_in_t rq;
        int      n;
        request_valid = 1'b0;
        result_stall  = 1'b0;
        request       = '0;
        quiet         = 1'b0;
        stim_done     = 1'b0;
        mismatches    = 0;
        crv_cubic     = 0;
        crv_square    = 0;
        crv_linear    = 0;
        crv_constant  = 0;
        seg_begin     = 0;
        seg_len       = 1;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the typed rows carry values readable straight off the math
        add_probe(mk_req(OP_SAMPLE, 0, 0, 0, 0), 1, 0, 0, 0, 0);           // reset curve
        add_probe(mk_req(OP_PLAN, 7, 65536, 0, 0), 1, 0, 0, 0, 1);         // zero length
        add_probe(mk_req(OP_REPLAN, 5, 0, 100, 0), 1, 0, 0, 0, 1);         // past end
        add_probe(mk_req(OP_PLAN, 100, 0, 65536, 1000000), 1, 0, 0, 393216, 0);
        add_probe(mk_req(OP_SAMPLE, 1000100, 0, 0, 0), 1, 65536, 0, -393216, 0);
        add_probe(mk_req(OP_SAMPLE, 0, 0, 0, 0), 0, 0, 0, 0, 0);           // before start
        add_probe(mk_req(OP_REPLAN, 500100, 0, -65536, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_REPLAN, 50, 0, 3 << 16, 0), 0, 0, 0, 0, 0);    // s0 clamps to 0
        add_probe(mk_req(OP_SAMPLE, 600000, 0, 0, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_REPLAN, 1000099, 0, 32'h7fff_0000, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_SAMPLE, 32'hffff_ffff, 0, 0, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_PLAN, 0, 32'h8000_0000, 32'h7fff_ffff, 1), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_SAMPLE, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_SAMPLE, 1, 0, 0, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_PLAN, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'hffff_ffff), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_REPLAN, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_SPARE, 123456, 32'h5555_5555, 32'haaaa_aaaa, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_PLAN, 1000, -1, 1, 3), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_REPLAN, 1001, 0, 32'h7fff_ffff, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_REPLAN, 1002, 0, 32'h8000_0000, 0), 0, 0, 0, 0, 0);
        add_probe(mk_req(OP_SAMPLE, 1003, 0, 0, 0), 0, 0, 0, 0, 0);
        foreach (probes[i])
            push_request(probes[i].rq, probes[i].typed, probes[i].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            rq = random_request();
            push_request(rq, 1'b0, '0);
        end
        request_valid <= 1'b0;
        quiet = 1'b0;
        stim_done = 1'b1;
    end

    //--------------------------------------------------------------------
    // Result side: random back-pressure, one draw per transfer
    //--------------------------------------------------------------------
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Compare each result transfer against the oldest pending expectation
    always @(posedge clk)
    begin
        ctr_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result transfer with nothing pending: %p", $realtime, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.position_out !== want.position_out
                    || result.velocity_out !== want.velocity_out
                    || result.acceleration_out !== want.acceleration_out
                    || result.error_flag !== want.error_flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: result mismatch pos %0d/%0d vel %0d/%0d acc %0d/%0d err %0b/%0b (exp/got)",
                                 $realtime, want.position_out, result.position_out,
                                 want.velocity_out, result.velocity_out,
                                 want.acceleration_out, result.acceleration_out,
                                 want.error_flag, result.error_flag);
                end
            end
        end
    end

    // Drain, then let the datapath settle before the verdict
    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: sized for the worst case of replans plus gaps and stalls
    initial
    begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
